// ===== hw/rtl/tdtq_pkg.sv =====
package tdtq_pkg;

  localparam int CoordBits  = 16;
  localparam int TimeBits   = 32;
  localparam int GapBits    = 16;
  localparam int DistBits   = 17;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 17;

  localparam logic [GapBits-1:0]  GapReset     = GapBits'(300);
  localparam logic [DistBits-1:0] DistReset    = DistBits'(64);
  localparam logic [GapBits-1:0]  TapMaxReset  = GapBits'(250);
  localparam logic [DistBits-1:0] MoveLimReset = DistBits'(8);

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [TimeBits-1:0]         stamp_t;
  typedef logic [CoordBits:0]          absd_t;
  typedef logic [CoordBits+1:0]        manh_t;

  typedef enum logic [1:0] {
    REQ_PRESS   = 2'd0,
    REQ_MOVE    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_GESTURE = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ACT_FORWARD    = 2'd0,
    ACT_FIT_WINDOW = 2'd1,
    ACT_SWALLOWED  = 2'd2,
    ACT_GESTURE    = 2'd3
  } action_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_DOUBLE_TAP_GAP_MS   = 2'd0,
    CFG_DOUBLE_TAP_DISTANCE = 2'd1,
    CFG_TAP_MAX_MS          = 2'd2,
    CFG_TAP_MOVE_LIMIT      = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [GapBits-1:0]  double_tap_gap_ms;
    logic [DistBits-1:0] double_tap_distance;
    logic [GapBits-1:0]  tap_max_ms;
    logic [DistBits-1:0] tap_move_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       primary_button;
    coord_t     pos_x;
    coord_t     pos_y;
    stamp_t     time_ms;
  } item_t;

  typedef struct packed {
    action_t action;
    logic    tap_recorded;
  } result_t;

  typedef struct packed {
    logic   swallowing;
    logic   tap_candidate;
    logic   gesture_seen;
    logic   press_valid;
    coord_t press_x;
    coord_t press_y;
    stamp_t press_time;
    logic   tap_valid;
    coord_t last_tap_x;
    coord_t last_tap_y;
    stamp_t last_tap_time;
  } tap_state_t;

  function automatic absd_t abs_diff(coord_t a, coord_t b);
    logic signed [CoordBits:0] d;
    d = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    return d[CoordBits] ? absd_t'(-d) : absd_t'(d);
  endfunction

  function automatic manh_t manhattan(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    return manh_t'(abs_diff(ax, bx)) + manh_t'(abs_diff(ay, by));
  endfunction

endpackage

// ===== hw/rtl/tdtq_if.sv =====
interface tdtq_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic                primary_button;
  tdtq_pkg::coord_t    pos_x;
  tdtq_pkg::coord_t    pos_y;
  tdtq_pkg::stamp_t    time_ms;

  modport source (output valid, req_type, primary_button, pos_x, pos_y, time_ms,
                  input ready);
  modport sink   (input valid, req_type, primary_button, pos_x, pos_y, time_ms,
                  output ready);
endinterface

interface tdtq_out_if;
  logic              valid;
  logic              ready;
  tdtq_pkg::action_t action;
  logic              tap_recorded;

  modport source (output valid, action, tap_recorded, input ready);
  modport sink   (input valid, action, tap_recorded, output ready);
endinterface

// ===== hw/rtl/tdtq_decide.sv =====
module tdtq_decide (
  input  tdtq_pkg::item_t      item,
  input  tdtq_pkg::tap_state_t st,
  input  tdtq_pkg::cfg_t       cfg,
  output tdtq_pkg::tap_state_t st_nxt,
  output tdtq_pkg::result_t    res
);

  tdtq_pkg::manh_t  tap_dist;
  tdtq_pkg::manh_t  move_dist;
  tdtq_pkg::stamp_t since_tap;
  tdtq_pkg::stamp_t since_press;
  logic             dbl_hit;
  logic             moved_far;
  logic             short_press;

  always_comb begin
    tap_dist    = tdtq_pkg::manhattan(item.pos_x, item.pos_y, st.last_tap_x, st.last_tap_y);
    move_dist   = tdtq_pkg::manhattan(item.pos_x, item.pos_y, st.press_x, st.press_y);
    since_tap   = item.time_ms - st.last_tap_time;
    since_press = item.time_ms - st.press_time;
    dbl_hit     = st.tap_valid
                  && (since_tap <= tdtq_pkg::stamp_t'(cfg.double_tap_gap_ms))
                  && (tap_dist <= tdtq_pkg::manh_t'(cfg.double_tap_distance));
    moved_far   = move_dist > tdtq_pkg::manh_t'(cfg.tap_move_limit);
    short_press = since_press <= tdtq_pkg::stamp_t'(cfg.tap_max_ms);
  end

  always_comb begin
    st_nxt           = st;
    res.action       = tdtq_pkg::ACT_FORWARD;
    res.tap_recorded = 1'b0;
    case (item.req_type)
      tdtq_pkg::REQ_PRESS: begin
        if (item.primary_button) begin
          if (dbl_hit) begin
            st_nxt.swallowing = 1'b1;
            st_nxt.tap_valid  = 1'b0;
            res.action        = tdtq_pkg::ACT_FIT_WINDOW;
          end else begin
            st_nxt.press_x       = item.pos_x;
            st_nxt.press_y       = item.pos_y;
            st_nxt.press_time    = item.time_ms;
            st_nxt.press_valid   = 1'b1;
            st_nxt.tap_candidate = 1'b1;
            st_nxt.gesture_seen  = 1'b0;
          end
        end
      end
      tdtq_pkg::REQ_MOVE: begin
        if (st.swallowing) begin
          res.action = tdtq_pkg::ACT_SWALLOWED;
        end else if (st.tap_candidate && moved_far) begin
          st_nxt.tap_candidate = 1'b0;
        end
      end
      tdtq_pkg::REQ_RELEASE: begin
        if (st.swallowing) begin
          st_nxt.swallowing = 1'b0;
          res.action        = tdtq_pkg::ACT_SWALLOWED;
        end else if (item.primary_button) begin
          if (st.tap_candidate && !st.gesture_seen && st.press_valid && short_press) begin
            st_nxt.last_tap_x    = item.pos_x;
            st_nxt.last_tap_y    = item.pos_y;
            st_nxt.last_tap_time = item.time_ms;
            st_nxt.tap_valid     = 1'b1;
            res.tap_recorded     = 1'b1;
          end else begin
            st_nxt.tap_valid = 1'b0;
          end
          st_nxt.tap_candidate = 1'b0;
        end
      end
      default: begin
        st_nxt.gesture_seen = 1'b1;
        res.action          = tdtq_pkg::ACT_GESTURE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/touch_double_tap_qualifier_unit.sv =====
// Double-tap qualifier for a stream of touch events.
// Touch events (press, move, release, gesture) enter on in_ch with a position and a
// millisecond timestamp; one classification per event leaves on out_ch, in order.
// Users must write thresholds via cfg_we, cfg_index and cfg_data while no event is
// in flight, not enforced by the block; each write takes effect at the next clock edge.
// An event accepted into the input register is classified by a single level of
// subtract and compare logic, and its result is registered in the result register
// as soon as that register is empty or its result is being taken on out_ch.
// One event is taken in every cycle while results are being taken; the limit is
// the tap-state update that each event needs before the next.
// A stall on out_ch holds the result register and the input register; once both
// are full, in_ch accepts no more until the result has been transferred.
// A synchronous reset on rst_n clears the tap state and empties both registers,
// and the thresholds return to 300 ms, 64 pixels, 250 ms and 8 pixels.
module touch_double_tap_qualifier_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tdtq_in_if.sink                              in_ch,
  tdtq_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [tdtq_pkg::CfgIdxBits-1:0]      cfg_index,
  input  logic [tdtq_pkg::CfgDataBits-1:0]     cfg_data
);

  tdtq_pkg::cfg_t       cfg_r;
  tdtq_pkg::tap_state_t st_r;
  tdtq_pkg::tap_state_t st_nxt;
  tdtq_pkg::item_t      s1_item_r;
  logic                 s1_valid_r;
  tdtq_pkg::result_t    res_nxt;
  tdtq_pkg::result_t    res_r;
  logic                 out_valid_r;
  logic                 load;

  assign load         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || load;
  assign out_ch.valid = out_valid_r;
  assign out_ch.action       = res_r.action;
  assign out_ch.tap_recorded = res_r.tap_recorded;

  tdtq_decide u_decide (
    .item   (s1_item_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.double_tap_gap_ms   <= tdtq_pkg::GapReset;
      cfg_r.double_tap_distance <= tdtq_pkg::DistReset;
      cfg_r.tap_max_ms          <= tdtq_pkg::TapMaxReset;
      cfg_r.tap_move_limit      <= tdtq_pkg::MoveLimReset;
    end else if (cfg_we) begin
      case (cfg_index)
        tdtq_pkg::CFG_DOUBLE_TAP_GAP_MS:
          cfg_r.double_tap_gap_ms <= cfg_data[tdtq_pkg::GapBits-1:0];
        tdtq_pkg::CFG_DOUBLE_TAP_DISTANCE:
          cfg_r.double_tap_distance <= cfg_data[tdtq_pkg::DistBits-1:0];
        tdtq_pkg::CFG_TAP_MAX_MS:
          cfg_r.tap_max_ms <= cfg_data[tdtq_pkg::GapBits-1:0];
        tdtq_pkg::CFG_TAP_MOVE_LIMIT:
          cfg_r.tap_move_limit <= cfg_data[tdtq_pkg::DistBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (load) begin
        s1_valid_r <= 1'b0;
      end
      if (load) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.req_type       <= in_ch.req_type;
      s1_item_r.primary_button <= in_ch.primary_button;
      s1_item_r.pos_x          <= in_ch.pos_x;
      s1_item_r.pos_y          <= in_ch.pos_y;
      s1_item_r.time_ms        <= in_ch.time_ms;
    end
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== sim/touch_double_tap_qualifier_unit_tb.sv =====
module touch_double_tap_qualifier_unit_tb;

  localparam int unsigned CycleLimit = 400000;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [tdtq_pkg::CfgIdxBits-1:0]  cfg_index;
  logic [tdtq_pkg::CfgDataBits-1:0] cfg_data;

  tdtq_in_if  in_if ();
  tdtq_out_if out_if ();

  touch_double_tap_qualifier_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted tap state and thresholds.
  logic              in_swallow;
  logic              cand_armed;
  logic              pinch_seen;
  logic              press_held;
  tdtq_pkg::coord_t  press_px;
  tdtq_pkg::coord_t  press_py;
  tdtq_pkg::stamp_t  press_stamp;
  logic              tap_stored;
  tdtq_pkg::coord_t  tap_px;
  tdtq_pkg::coord_t  tap_py;
  tdtq_pkg::stamp_t  tap_stamp;
  logic [15:0]       gap_lim;
  logic [16:0]       dist_lim;
  logic [15:0]       tap_lim;
  logic [16:0]       move_lim;

  tdtq_pkg::result_t predicted_results[$];
  int unsigned       mismatch_count;
  int unsigned       events_sent;
  int unsigned       cycle_count;
  int                stall_left;
  logic              gaps_on;
  logic              stalls_on;

  // Stimulus generator position and clock.
  tdtq_pkg::stamp_t  gen_now;
  tdtq_pkg::coord_t  gen_x;
  tdtq_pkg::coord_t  gen_y;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 5);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    tdtq_pkg::result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result transfer with no event outstanding: action %0d tap_recorded %0b",
               out_if.action, out_if.tap_recorded);
        mismatch_count++;
      end else begin
        want = predicted_results.pop_front();
        if (out_if.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_if.action);
          mismatch_count++;
        end
        if (out_if.tap_recorded !== want.tap_recorded) begin
          $error("tap_recorded: expected %0b, got %0b", want.tap_recorded,
                 out_if.tap_recorded);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int unsigned span(tdtq_pkg::coord_t ax, tdtq_pkg::coord_t ay,
                                       tdtq_pkg::coord_t bx, tdtq_pkg::coord_t by);
    int dx;
    int dy;
    dx = int'(ax) - int'(bx);
    dy = int'(ay) - int'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return unsigned'(dx + dy);
  endfunction

  function automatic tdtq_pkg::result_t classify_event(tdtq_pkg::item_t ev);
    tdtq_pkg::result_t r;
    tdtq_pkg::stamp_t  since_tap;
    tdtq_pkg::stamp_t  held_for;
    r.action       = tdtq_pkg::ACT_FORWARD;
    r.tap_recorded = 1'b0;
    since_tap = ev.time_ms - tap_stamp;
    held_for  = ev.time_ms - press_stamp;
    case (ev.req_type)
      tdtq_pkg::REQ_PRESS: begin
        if (ev.primary_button) begin
          if (tap_stored && since_tap <= gap_lim &&
              span(ev.pos_x, ev.pos_y, tap_px, tap_py) <= dist_lim) begin
            in_swallow = 1'b1;
            tap_stored = 1'b0;
            r.action   = tdtq_pkg::ACT_FIT_WINDOW;
          end else begin
            press_px    = ev.pos_x;
            press_py    = ev.pos_y;
            press_stamp = ev.time_ms;
            press_held  = 1'b1;
            cand_armed  = 1'b1;
            pinch_seen  = 1'b0;
          end
        end
      end
      tdtq_pkg::REQ_MOVE: begin
        if (in_swallow) begin
          r.action = tdtq_pkg::ACT_SWALLOWED;
        end else if (cand_armed &&
                     span(ev.pos_x, ev.pos_y, press_px, press_py) > move_lim) begin
          cand_armed = 1'b0;
        end
      end
      tdtq_pkg::REQ_RELEASE: begin
        if (in_swallow) begin
          in_swallow = 1'b0;
          r.action   = tdtq_pkg::ACT_SWALLOWED;
        end else if (ev.primary_button) begin
          if (cand_armed && !pinch_seen && press_held && held_for <= tap_lim) begin
            tap_px         = ev.pos_x;
            tap_py         = ev.pos_y;
            tap_stamp      = ev.time_ms;
            tap_stored     = 1'b1;
            r.tap_recorded = 1'b1;
          end else begin
            tap_stored = 1'b0;
          end
          cand_armed = 1'b0;
        end
      end
      default: begin
        pinch_seen = 1'b1;
        r.action   = tdtq_pkg::ACT_GESTURE;
      end
    endcase
    return r;
  endfunction

  function automatic tdtq_pkg::item_t make_event(logic [1:0] kind, logic prim, int x, int y,
                                                 tdtq_pkg::stamp_t t);
    tdtq_pkg::item_t ev;
    ev.req_type       = kind;
    ev.primary_button = prim;
    ev.pos_x          = tdtq_pkg::coord_t'(x);
    ev.pos_y          = tdtq_pkg::coord_t'(y);
    ev.time_ms        = t;
    return ev;
  endfunction

  function automatic tdtq_pkg::coord_t nudge(tdtq_pkg::coord_t c, logic [16:0] lim);
    int reach;
    int off;
    reach = (lim > 4000) ? 2000 : int'(lim) / 2 + 2;
    off   = int'($urandom_range(0, 2 * reach)) - reach;
    return tdtq_pkg::coord_t'(int'(c) + off);
  endfunction

  task automatic send_event(input tdtq_pkg::item_t ev);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.req_type       <= ev.req_type;
    in_if.primary_button <= ev.primary_button;
    in_if.pos_x          <= ev.pos_x;
    in_if.pos_y          <= ev.pos_y;
    in_if.time_ms        <= ev.time_ms;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted_results.push_back(classify_event(ev));
    events_sent++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_thresholds(input logic [15:0] gap, input logic [16:0] dist_val,
                                  input logic [15:0] tmax, input logic [16:0] move);
    cfg_we    <= 1'b1;
    cfg_index <= tdtq_pkg::CFG_DOUBLE_TAP_GAP_MS;
    cfg_data  <= tdtq_pkg::CfgDataBits'(gap);
    @(posedge clk);
    cfg_index <= tdtq_pkg::CFG_DOUBLE_TAP_DISTANCE;
    cfg_data  <= dist_val;
    @(posedge clk);
    cfg_index <= tdtq_pkg::CFG_TAP_MAX_MS;
    cfg_data  <= tdtq_pkg::CfgDataBits'(tmax);
    @(posedge clk);
    cfg_index <= tdtq_pkg::CFG_TAP_MOVE_LIMIT;
    cfg_data  <= move;
    @(posedge clk);
    cfg_we   <= 1'b0;
    gap_lim  = gap;
    dist_lim = dist_val;
    tap_lim  = tmax;
    move_lim = move;
  endtask

  task automatic send_noise();
    send_event(make_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          tdtq_pkg::coord_t'($urandom), tdtq_pkg::coord_t'($urandom),
                          $urandom));
  endtask

  // One press, up to three moves or gestures and a release, placed near the last release most of the time.
  task automatic run_session();
    tdtq_pkg::coord_t px;
    tdtq_pkg::coord_t py;
    if ($urandom_range(0, 7) == 0) begin
      gen_now += $urandom;
    end else begin
      gen_now += $urandom_range(0, int'(gap_lim) + int'(gap_lim) / 4 + 20);
    end
    if ($urandom_range(0, 2) != 0) begin
      px = nudge(gen_x, dist_lim);
      py = nudge(gen_y, dist_lim);
    end else begin
      px = tdtq_pkg::coord_t'($urandom);
      py = tdtq_pkg::coord_t'($urandom);
    end
    send_event(make_event(tdtq_pkg::REQ_PRESS, $urandom_range(0, 9) != 0, px, py, gen_now));
    repeat ($urandom_range(0, 3)) begin
      gen_now += $urandom_range(0, 40);
      if ($urandom_range(0, 9) == 0) begin
        send_event(make_event(tdtq_pkg::REQ_GESTURE, 1'($urandom_range(0, 1)), px, py,
                              gen_now));
      end else begin
        send_event(make_event(tdtq_pkg::REQ_MOVE, 1'($urandom_range(0, 1)),
                              nudge(px, move_lim), nudge(py, move_lim), gen_now));
      end
    end
    gen_now += $urandom_range(0, int'(tap_lim) + int'(tap_lim) / 4 + 20);
    gen_x = nudge(px, move_lim);
    gen_y = nudge(py, move_lim);
    send_event(make_event(tdtq_pkg::REQ_RELEASE, $urandom_range(0, 9) != 0, gen_x, gen_y,
                          gen_now));
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned target;
    target = events_sent + count;
    while (events_sent < target) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end else begin
        run_session();
      end
    end
  endtask

  task automatic test_directed_cases();
    settle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_thresholds(tdtq_pkg::GapReset, tdtq_pkg::DistReset, tdtq_pkg::TapMaxReset,
                     tdtq_pkg::MoveLimReset);
    send_event(make_event(tdtq_pkg::REQ_RELEASE, 1'b1, 0, 0, 32'd100));
    send_event(make_event(tdtq_pkg::REQ_PRESS, 1'b1, 10, 10, 32'd1000));
    send_event(make_event(tdtq_pkg::REQ_RELEASE, 1'b1, 12, 10, 32'd1250));
    send_event(make_event(tdtq_pkg::REQ_PRESS, 1'b1, -20, 40, 32'd1550));
    send_event(make_event(tdtq_pkg::REQ_MOVE, 1'b1, 500, 500, 32'd1560));
    send_event(make_event(tdtq_pkg::REQ_PRESS, 1'b1, 12, 10, 32'd1570));
    send_event(make_event(tdtq_pkg::REQ_RELEASE, 1'b0, 0, 0, 32'd1580));
    send_event(make_event(tdtq_pkg::REQ_PRESS, 1'b0, 0, 0, 32'd1600));
    send_event(make_event(tdtq_pkg::REQ_RELEASE, 1'b1, 12, 10, 32'd1700));
    send_event(make_event(tdtq_pkg::REQ_PRESS, 1'b1, 12, 10, 32'd2001));
    send_event(make_event(tdtq_pkg::REQ_MOVE, 1'b1, 20, 11, 32'd2010));
    send_event(make_event(tdtq_pkg::REQ_RELEASE, 1'b1, 12, 10, 32'd2020));
    send_event(make_event(tdtq_pkg::REQ_PRESS, 1'b1, 12, 10, 32'd2030));
    send_event(make_event(tdtq_pkg::REQ_GESTURE, 1'b0, 0, 0, 32'd2040));
    send_event(make_event(tdtq_pkg::REQ_RELEASE, 1'b1, 12, 10, 32'd2050));
    send_event(make_event(tdtq_pkg::REQ_PRESS, 1'b1, -32768, 32767, 32'hFFFF_FFF0));
    send_event(make_event(tdtq_pkg::REQ_MOVE, 1'b0, -32764, 32763, 32'hFFFF_FFF8));
    send_event(make_event(tdtq_pkg::REQ_RELEASE, 1'b0, 0, 0, 32'h0000_0000));
    send_event(make_event(tdtq_pkg::REQ_RELEASE, 1'b1, -32768, 32767, 32'h0000_0020));
    send_event(make_event(tdtq_pkg::REQ_PRESS, 1'b1, 32767, -32768, 32'h0000_0030));
    send_event(make_event(tdtq_pkg::REQ_RELEASE, 1'b1, 32767, -32768, 32'h0000_012B));
    send_event(make_event(tdtq_pkg::REQ_GESTURE, 1'b1, -1, -1, 32'h0000_0200));
    send_event(make_event(tdtq_pkg::REQ_MOVE, 1'b1, 32767, 32767, 32'h0000_0210));
  endtask

  task automatic test_threshold_extremes();
    settle();
    write_thresholds(16'd0, 17'd0, 16'd0, 17'd0);
    run_phase(120);
    settle();
    stalls_on = 1'b0;
    write_thresholds(16'd65535, 17'd131070, 16'd65535, 17'd131070);
    run_phase(120);
  endtask

  task automatic test_random_sessions();
    for (int p = 0; p < 5; p++) begin
      settle();
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      if (p == 2) begin
        write_thresholds(16'($urandom), 17'($urandom_range(0, 131070)), 16'($urandom),
                         17'($urandom_range(0, 131070)));
      end else begin
        write_thresholds(16'($urandom_range(0, 600)), 17'($urandom_range(0, 100)),
                         16'($urandom_range(0, 400)), 17'($urandom_range(0, 30)));
      end
      run_phase(160);
    end
  endtask

  task automatic test_quiet_tail();
    settle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_thresholds(tdtq_pkg::GapReset, tdtq_pkg::DistReset, tdtq_pkg::TapMaxReset,
                     tdtq_pkg::MoveLimReset);
    run_phase(150);
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_if.valid          = 1'b0;
    in_if.req_type       = '0;
    in_if.primary_button = 1'b0;
    in_if.pos_x          = '0;
    in_if.pos_y          = '0;
    in_if.time_ms        = '0;
    gaps_on              = 1'b0;
    stalls_on            = 1'b0;
    events_sent          = 0;
    in_swallow           = 1'b0;
    cand_armed           = 1'b0;
    pinch_seen           = 1'b0;
    press_held           = 1'b0;
    press_px             = '0;
    press_py             = '0;
    press_stamp          = '0;
    tap_stored           = 1'b0;
    tap_px               = '0;
    tap_py               = '0;
    tap_stamp            = '0;
    gap_lim              = tdtq_pkg::GapReset;
    dist_lim             = tdtq_pkg::DistReset;
    tap_lim              = tdtq_pkg::TapMaxReset;
    move_lim             = tdtq_pkg::MoveLimReset;
    gen_now              = '0;
    gen_x                = '0;
    gen_y                = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_threshold_extremes();
    test_random_sessions();
    test_quiet_tail();
    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
